// ===== rtl/epfm_pkg.sv =====
// shared widths and constants of the edge pair frequency meter
`timescale 1ns / 1ps

package epfm_pkg;

    localparam int TIME_WIDTH  = 32;
    localparam int COUNT_WIDTH = 32;
    localparam int PERIOD_W    = 16;

    // result frequency: unsigned q19.8, full scale 500000 hz
    localparam int FREQ_W = 27;
    localparam logic [FREQ_W-1:0] FREQ_FULL = 27'd128000000;

    // full scale = FREQ_ODD * 2**FREQ_SHIFT
    localparam int ODD_W      = 14;
    localparam int FREQ_SHIFT = FREQ_W - ODD_W;
    localparam logic [ODD_W-1:0] FREQ_ODD = 14'd15625;
    localparam int PROD_W = COUNT_WIDTH + ODD_W;

    // quotient bit counter
    localparam int QCNT_W = $clog2(FREQ_W);

    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd5000;

    // configuration space
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic REG_IDX_PERIOD = 1'b0;

endpackage

// ===== rtl/epfm_divider.sv =====
// radix-2 divider: floor(full_scale * pairs / sum), one quotient bit per cycle
`timescale 1ns / 1ps

module epfm_divider
    import epfm_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   start,
    input  logic [COUNT_WIDTH-1:0] pairs,     // must be below sum
    input  logic [TIME_WIDTH-1:0]  sum,       // nonzero
    output logic                   done,
    output logic [FREQ_W-1:0]      quotient
);

    typedef enum logic [1:0] {
        D_IDLE,
        D_MUL,
        D_DIV
    } div_state_t;

    div_state_t              state_reg;
    logic                    done_reg;
    logic [QCNT_W-1:0]       cnt_reg;
    logic [TIME_WIDTH-1:0]   rem_reg;
    logic [FREQ_W-1:0]       low_reg;      // low dividend bits, msb first
    logic [FREQ_W-1:0]       q_reg;

    logic [PROD_W-1:0]       prod;
    logic [TIME_WIDTH:0]     trial;
    logic [TIME_WIDTH:0]     diff;
    logic                    q_bit;

    // pairs * odd part of full scale; the power of two part is the zero tail
    assign prod  = PROD_W'(pairs) * PROD_W'(FREQ_ODD);

    assign trial = {rem_reg, low_reg[FREQ_W-1]};
    assign diff  = trial - {1'b0, sum};
    assign q_bit = (trial >= {1'b0, sum});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= D_IDLE;
            done_reg  <= 1'b0;
            cnt_reg   <= '0;
        end else begin
            done_reg <= 1'b0;
            case (state_reg)
                D_IDLE: begin
                    if (start) begin
                        state_reg <= D_MUL;
                    end
                end
                D_MUL: begin
                    // top of dividend is below sum since pairs < sum
                    rem_reg   <= TIME_WIDTH'(prod[PROD_W-1:ODD_W]);
                    low_reg   <= {prod[ODD_W-1:0], {FREQ_SHIFT{1'b0}}};
                    cnt_reg   <= '0;
                    state_reg <= D_DIV;
                end
                D_DIV: begin
                    rem_reg <= q_bit ? diff[TIME_WIDTH-1:0] : trial[TIME_WIDTH-1:0];
                    low_reg <= {low_reg[FREQ_W-2:0], 1'b0};
                    q_reg   <= {q_reg[FREQ_W-2:0], q_bit};
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == QCNT_W'(FREQ_W - 1)) begin
                        done_reg  <= 1'b1;
                        state_reg <= D_IDLE;
                    end
                end
                default: begin
                    state_reg <= D_IDLE;
                end
            endcase
        end
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

// ===== rtl/edge_pair_frequency_meter.sv =====
// top level of the edge pair frequency meter: pairing, windowing and result port
//
// channel  | handshake              | payload
// ---------+------------------------+----------------------------------------------
// s_       | s_tvalid / s_tready    | s_tdata: edge_time_us, edge_time_ms
// m_       | m_tvalid / m_tready    | m_tdata: frequency_q8, pair_count; m_tuser: zero_interval
// apb      | psel / penable / pready| reg 0 at byte 0: report_period_ms
//
// an edge that reports nothing is taken in the idle state; a saturated report goes
// straight to the hand-over; a divided report passes the radix-2 divider (start,
// multiply step, 27 quotient bits at one bit per cycle, done) and then the hand-over
// synchronous active-low reset clears pairing, sum, count and window start
// a finished result sits in the output register; a stalled m_ side holds the
// block in its final step only when a new result is ready behind the old one
`timescale 1ns / 1ps

module edge_pair_frequency_meter
    import epfm_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,

    // input beats
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [63:0]           s_tdata,    // [31:0] edge_time_us, [63:32] edge_time_ms

    // result beats
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [63:0]           m_tdata,    // [26:0] frequency_q8, [58:27] pair_count, rest 0
    output logic                  m_tuser,    // [0] zero_interval

    // configuration
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_DONE
    } state_t;

    state_t                  state_reg;
    logic [PERIOD_W-1:0]     period_reg;
    logic                    pair_open_reg;
    logic [TIME_WIDTH-1:0]   first_us_reg;
    logic [TIME_WIDTH-1:0]   sum_reg;
    logic [COUNT_WIDTH-1:0]  pairs_reg;
    logic [TIME_WIDTH-1:0]   win_start_reg;

    // operands and pending result of the report in flight
    logic [TIME_WIDTH-1:0]   div_sum_reg;
    logic [COUNT_WIDTH-1:0]  div_pairs_reg;
    logic                    div_start_reg;
    logic [FREQ_W-1:0]       res_freq_reg;
    logic                    res_zero_reg;

    // output register
    logic                    m_valid_reg;
    logic [FREQ_W-1:0]       m_freq_reg;
    logic [COUNT_WIDTH-1:0]  m_pairs_reg;
    logic                    m_zero_reg;

    logic [TIME_WIDTH-1:0]   in_us;
    logic [TIME_WIDTH-1:0]   in_ms;
    logic                    in_accept;
    logic [TIME_WIDTH-1:0]   sum_next;
    logic [COUNT_WIDTH-1:0]  pairs_next;
    logic [TIME_WIDTH-1:0]   elapsed_ms;
    logic                    report;
    logic                    cfg_write;
    logic                    div_done;
    logic [FREQ_W-1:0]       div_q;
    logic                    out_free;

    assign in_us     = s_tdata[TIME_WIDTH-1:0];
    assign in_ms     = s_tdata[2*TIME_WIDTH-1:TIME_WIDTH];
    assign s_tready  = (state_reg == ST_IDLE);
    assign in_accept = s_tvalid && s_tready;

    // interval of this pair wraps with the timestamp
    assign sum_next   = sum_reg + (in_us - first_us_reg);
    assign pairs_next = pairs_reg + 1'b1;
    assign elapsed_ms = in_ms - win_start_reg;
    assign report     = (elapsed_ms >= TIME_WIDTH'(period_reg));

    assign out_free  = !m_valid_reg || m_tready;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[2] == REG_IDX_PERIOD) ? APB_DATA_W'(period_reg) : '0;

    epfm_divider u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start_reg),
        .pairs    (div_pairs_reg),
        .sum      (div_sum_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            period_reg    <= PERIOD_RESET;
            pair_open_reg <= 1'b0;
            first_us_reg  <= '0;
            sum_reg       <= '0;
            pairs_reg     <= '0;
            win_start_reg <= '0;
            div_start_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            div_start_reg <= 1'b0;

            if (cfg_write && (paddr[2] == REG_IDX_PERIOD)) begin
                period_reg <= pwdata[PERIOD_W-1:0];
            end

            if (m_valid_reg && m_tready) begin
                m_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE: begin
                    if (in_accept) begin
                        if (!pair_open_reg) begin
                            // first edge of a pair
                            first_us_reg  <= in_us;
                            pair_open_reg <= 1'b1;
                        end else begin
                            pair_open_reg <= 1'b0;
                            if (!report) begin
                                sum_reg   <= sum_next;
                                pairs_reg <= pairs_next;
                            end else begin
                                // close the window
                                sum_reg       <= '0;
                                pairs_reg     <= '0;
                                win_start_reg <= in_ms;
                                div_sum_reg   <= sum_next;
                                div_pairs_reg <= pairs_next;
                                if (sum_next == '0) begin
                                    res_freq_reg <= FREQ_FULL;
                                    res_zero_reg <= 1'b1;
                                    state_reg    <= ST_DONE;
                                end else if (TIME_WIDTH'(pairs_next) >= sum_next) begin
                                    // at or above full scale
                                    res_freq_reg <= FREQ_FULL;
                                    res_zero_reg <= 1'b0;
                                    state_reg    <= ST_DONE;
                                end else begin
                                    res_zero_reg  <= 1'b0;
                                    div_start_reg <= 1'b1;
                                    state_reg     <= ST_DIV;
                                end
                            end
                        end
                    end
                end
                ST_DIV: begin
                    if (div_done) begin
                        res_freq_reg <= div_q;
                        state_reg    <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    // hand over once the output register is free
                    if (out_free) begin
                        m_valid_reg <= 1'b1;
                        m_freq_reg  <= res_freq_reg;
                        m_pairs_reg <= div_pairs_reg;
                        m_zero_reg  <= res_zero_reg;
                        state_reg   <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(64 - FREQ_W - COUNT_WIDTH){1'b0}}, m_pairs_reg, m_freq_reg};
    assign m_tuser  = m_zero_reg;

endmodule

// ===== tb/edge_pair_frequency_meter_test.sv =====
// self-checking bench for the edge pair frequency meter: predicted reports against result beats
`timescale 1ns / 1ps

module edge_pair_frequency_meter_test;
    import epfm_pkg::*;

    // generous bound: every item with a long sender gap, a full divide and a long receiver stall
    localparam int CYCLE_LIMIT   = 500000;
    // an edge without a report may still be in flight after the last report came out
    localparam int SETTLE_CYCLES = 40;
    localparam logic [APB_ADDR_W-1:0] PERIOD_ADDR = APB_ADDR_W'(4 * REG_IDX_PERIOD);
    // no register lives here, a write must leave the period alone
    localparam logic [APB_ADDR_W-1:0] SPARE_ADDR  = APB_ADDR_W'(4);

    typedef struct {
        logic [FREQ_W-1:0]      freq_q8;
        logic [COUNT_WIDTH-1:0] pairs;
        logic                   zero_sum;
    } freq_report_t;

    // tracks pairing and windowing, keeps the reports still to come out
    class freq_report_ledger;
        logic [PERIOD_W-1:0]    period_ms;
        logic                   pair_open;
        logic [TIME_WIDTH-1:0]  first_us;
        logic [TIME_WIDTH-1:0]  sum_us;
        logic [COUNT_WIDTH-1:0] pairs;
        logic [TIME_WIDTH-1:0]  window_ms;
        freq_report_t           pending_reports[$];
        int                     mismatch_count;

        function new();
            period_ms      = PERIOD_RESET;
            pair_open      = 1'b0;
            first_us       = '0;
            sum_us         = '0;
            pairs          = '0;
            window_ms      = '0;
            mismatch_count = 0;
        endfunction

        task log_mismatch(string what);
            mismatch_count++;
            $display("mismatch at %0t ns: %s", $time, what);
        endtask

        // one accepted edge beat
        function void take_edge(logic [TIME_WIDTH-1:0] us, logic [TIME_WIDTH-1:0] ms);
            logic [TIME_WIDTH-1:0] since_ms;
            logic [63:0]           scaled;
            freq_report_t          rep;
            if (!pair_open) begin
                first_us  = us;
                pair_open = 1'b1;
                return;
            end
            pair_open = 1'b0;
            sum_us    = sum_us + (us - first_us);
            pairs     = pairs + 1'b1;
            since_ms  = ms - window_ms;
            if (since_ms < TIME_WIDTH'(period_ms))
                return;
            rep.pairs    = pairs;
            rep.zero_sum = (sum_us == '0);
            // a zero sum also lands here and saturates
            if (pairs >= sum_us)
                rep.freq_q8 = FREQ_FULL;
            else begin
                scaled      = 64'(pairs) * 64'(FREQ_FULL);
                rep.freq_q8 = FREQ_W'(scaled / 64'(sum_us));
            end
            pending_reports.push_back(rep);
            window_ms = ms;
            sum_us    = '0;
            pairs     = '0;
        endfunction

        // one accepted result beat
        task match_report(logic [FREQ_W-1:0] freq_q8, logic [COUNT_WIDTH-1:0] cnt,
                          logic zero_sum);
            freq_report_t want;
            if (pending_reports.size() == 0) begin
                log_mismatch($sformatf("unexpected report freq_q8 %0d pairs %0d zero %0b",
                                       freq_q8, cnt, zero_sum));
                return;
            end
            want = pending_reports.pop_front();
            if (freq_q8 !== want.freq_q8)
                log_mismatch($sformatf("freq_q8 %0d, want %0d", freq_q8, want.freq_q8));
            if (cnt !== want.pairs)
                log_mismatch($sformatf("pair_count %0d, want %0d", cnt, want.pairs));
            if (zero_sum !== want.zero_sum)
                log_mismatch($sformatf("zero_interval %0b, want %0b", zero_sum, want.zero_sum));
        endtask
    endclass

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [63:0]           s_tdata;    // [31:0] edge_time_us, [63:32] edge_time_ms
    logic                  m_tvalid;
    logic                  m_tready;
    logic [63:0]           m_tdata;    // [26:0] frequency_q8, [58:27] pair_count
    logic                  m_tuser;    // [0] zero_interval
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    freq_report_ledger ledger;

    int          cycles;
    int          s_calm;      // sender beats left with no gap
    int          m_hold;      // receiver stall cycles left
    int          m_calm;      // receiver cycles left with no stall
    logic [31:0] run_us;      // running timestamps of the well-formed traffic
    logic [31:0] run_ms;

    edge_pair_frequency_meter dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #1 aclk = ~aclk;

    // watchdog
    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // microseconds between edges: typical, tiny (saturation), or anything
    function automatic logic [31:0] pick_interval();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 2000);
        if (r < 90)
            return $urandom_range(0, 3);
        return $urandom;
    endfunction

    // receiver backpressure, changed at the falling edge
    always @(negedge aclk) begin
        if (m_hold > 0) begin
            m_hold--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
            if (m_calm > 0)
                m_calm--;
            else if ($urandom_range(0, 99) < 2)
                m_calm = $urandom_range(30, 80);
            else if ($urandom_range(0, 99) < 15)
                m_hold = pick_gap();
        end
    end

    // every accepted result beat goes to the ledger
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            ledger.match_report(m_tdata[FREQ_W-1:0], m_tdata[FREQ_W +: COUNT_WIDTH], m_tuser);
    end

    // one edge beat; returns right after the edge that accepted it
    task automatic send_edge(input logic [31:0] us, input logic [31:0] ms);
        int gap;
        gap = 0;
        if (s_calm > 0)
            s_calm--;
        else if ($urandom_range(0, 99) < 2)
            s_calm = $urandom_range(20, 60);
        else
            gap = pick_gap();
        @(negedge aclk);
        // valid only drops when a gap follows, so it never falls and rises in one step
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {ms, us};
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        ledger.take_edge(us, ms);
    endtask

    task automatic apb_write(input logic [APB_ADDR_W-1:0] addr,
                             input logic [APB_DATA_W-1:0] data);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready)
            @(posedge aclk);
        if (addr == PERIOD_ADDR)
            ledger.period_ms = data[PERIOD_W-1:0];
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // read the period back and hold it against the ledger
    task automatic apb_check_period();
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= PERIOD_ADDR;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready)
            @(posedge aclk);
        if (prdata !== APB_DATA_W'(ledger.period_ms))
            ledger.log_mismatch($sformatf("period reads %0d, want %0d", prdata,
                                          ledger.period_ms));
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // upper data bits are junk on purpose, the register keeps 16
    task automatic set_period(input logic [PERIOD_W-1:0] period);
        apb_write(PERIOD_ADDR, {16'($urandom), period});
        apb_check_period();
    endtask

    // stop sending, wait out the reports and any edge still inside
    task automatic settle();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (ledger.pending_reports.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // mostly a steadily running clock pair, some repeated stamps and some noise
    task automatic run_traffic(input int count, input int ms_step);
        int kind;
        for (int i = 0; i < count; i++) begin
            kind = $urandom_range(0, 99);
            if (kind < 80) begin
                run_us = run_us + pick_interval();
                run_ms = run_ms + $urandom_range(0, ms_step);
                send_edge(run_us, run_ms);
            end else if (kind < 88)
                send_edge(run_us, run_ms);
            else
                send_edge($urandom, $urandom);
        end
    endtask

    initial begin
        int period;
        ledger   = new();
        aclk     = 1'b0;
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        m_tready = 1'b1;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        s_calm   = 0;
        run_us   = '0;
        run_ms   = '0;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // reset period 5000 ms, window start 0
        apb_check_period();
        // one pair just short of the period: no report
        send_edge(32'd0, 32'd0);
        send_edge(32'd100, 32'd4999);
        // microsecond wrap inside a pair, period reached exactly
        send_edge(32'hFFFF_FFF0, 32'd5000);
        send_edge(32'h0000_0010, 32'd5000);
        // two zero-length pairs: zero sum, saturated and flagged
        send_edge(32'd7, 32'd5001);
        send_edge(32'd7, 32'd9999);
        send_edge(32'd123, 32'd10000);
        send_edge(32'd123, 32'd10000);
        // two pairs over one microsecond: above full scale, saturated without flag
        send_edge(32'd5, 32'd12000);
        send_edge(32'd6, 32'd12000);
        send_edge(32'd9, 32'd15000);
        send_edge(32'd9, 32'd15000);
        // longest possible interval, all-ones stamps
        send_edge(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_edge(32'hFFFF_FFFE, 32'hFFFF_FFFF);
        // millisecond wrap across the window
        send_edge(32'd1000, 32'd2000);
        send_edge(32'd1250, 32'd4999);
        // plain divided report
        send_edge(32'h5555_5555, 32'hAAAA_AAAA);
        send_edge(32'h5555_9999, 32'hAAAA_BBBB);
        settle();

        // zero period: every completed pair reports
        set_period(16'd0);
        run_traffic(110, 2);
        settle();

        set_period(16'd1);
        run_traffic(110, 2);
        settle();

        // write to the empty slot, the period must not move
        apb_write(SPARE_ADDR, $urandom);
        apb_check_period();

        set_period(16'hFFFF);
        run_traffic(100, 32769);
        settle();

        repeat (2) begin
            period = $urandom_range(2, 9000);
            set_period(PERIOD_W'(period));
            run_traffic(130, period / 2 + 2);
            settle();
        end

        if (ledger.mismatch_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/epfm_pkg.sv
rtl/epfm_divider.sv
rtl/edge_pair_frequency_meter.sv
tb/edge_pair_frequency_meter_test.sv
